FILE: rtl/cfe_pkg.sv
// ----------------------------------------------------------------------------
// Command frame encoder package
// Shared constants, the job type passed from front to back, and step codes.
// ----------------------------------------------------------------------------
package cfe_pkg;

   localparam int BYTE_W = 8;

   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hF5;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h5F;

   // Default depth of the job queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;

   // One job is everything the back needs to emit the bytes caused by one item.
   typedef struct packed {
      logic              has_header;   // sync, device, command and length bytes
      logic              has_data;     // one payload byte
      logic              has_checksum; // checksum byte closes the frame
      logic [BYTE_W-1:0] device;
      logic [BYTE_W-1:0] command;
      logic [BYTE_W-1:0] length;
      logic [BYTE_W-1:0] data_byte;
      logic [BYTE_W-1:0] checksum;
   } job_type;

   // Position of the byte being emitted within one job.
   typedef enum logic [2:0] {
      STEP_SYNC_A,
      STEP_SYNC_B,
      STEP_DEVICE,
      STEP_COMMAND,
      STEP_LENGTH,
      STEP_DATA,
      STEP_CHECKSUM
   } step_type;

endpackage

FILE: rtl/command_frame_encoder_top.sv
// ----------------------------------------------------------------------------
// Command frame encoder top level
// Turns frame starts and payload items into a serial command byte stream.
// ----------------------------------------------------------------------------
// Usage:
// Items enter through a queue-style port: an item is taken at a rising edge
// with req_push high and req_full low. A start item emits 0xF5, 0x5F, device,
// command and length, then its data byte unless length is zero, and the
// checksum when the frame ends there. A later payload item emits its data
// byte, plus the checksum when it is the last one. Non-start items while idle
// are taken and dropped. A new start abandons an unfinished frame.
// Results leave through a queue-style port: while rsp_empty is low, the
// oldest byte is on the rsp_ ports and rsp_pop takes it.
// The front tracks the frame state and classifies each item in its accept
// cycle, then hands a job to a short queue. While the receiver pops, the
// back walks the head job one byte per cycle into a single output register.
// The first byte of an item passes through the queue and then the output
// register to the rsp_ ports. Payload items without a checksum thus flow at
// one item per cycle; the queue absorbs the longer hold of a start item.
// When the receiver stalls, the output register holds, the back waits, and
// req_full rises once the queue fills. Synchronous reset empties the queue
// and the output register and returns the frame state to idle.
// ----------------------------------------------------------------------------
module command_frame_encoder_top #(
   parameter int QUEUE_DEPTH = cfe_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic                       req_frame_start,
   input  logic [cfe_pkg::BYTE_W-1:0] req_device,
   input  logic [cfe_pkg::BYTE_W-1:0] req_command,
   input  logic [cfe_pkg::BYTE_W-1:0] req_length,
   input  logic [cfe_pkg::BYTE_W-1:0] req_data_byte,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [cfe_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                       rsp_last_of_run,
   output logic                       rsp_frame_end
);

   logic             accept;
   logic             job_push;
   cfe_pkg::job_type push_job;
   cfe_pkg::job_type head_job;
   logic             job_pop;
   logic             job_full;
   logic             job_empty;

   // Every item is held off while the queue is full, including ones that
   // would produce no job, so the frame state never runs ahead of the queue.
   assign req_full = job_full;
   assign accept   = req_push && !job_full;

   cfe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_start (req_frame_start),
      .device      (req_device),
      .command     (req_command),
      .length      (req_length),
      .data_byte   (req_data_byte),
      .job_push    (job_push),
      .job         (push_job)
   );

   cfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head_job (head_job),
      .full     (job_full),
      .empty    (job_empty)
   );

   cfe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_empty       (job_empty),
      .job             (head_job),
      .job_pop         (job_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule

FILE: rtl/cfe_front.sv
// ----------------------------------------------------------------------------
// Command frame encoder front end
// Tracks frame state per accepted item and turns each item into a job.
// ----------------------------------------------------------------------------
module cfe_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic                       frame_start,
   input  logic [cfe_pkg::BYTE_W-1:0] device,
   input  logic [cfe_pkg::BYTE_W-1:0] command,
   input  logic [cfe_pkg::BYTE_W-1:0] length,
   input  logic [cfe_pkg::BYTE_W-1:0] data_byte,
   output logic                       job_push,
   output cfe_pkg::job_type           job
);

   logic [cfe_pkg::BYTE_W-1:0] sum_ff, sum_in;
   logic [cfe_pkg::BYTE_W-1:0] left_ff, left_in;
   logic                       in_frame_ff, in_frame_in;
   logic [cfe_pkg::BYTE_W-1:0] header_sum;
   logic [cfe_pkg::BYTE_W-1:0] base_sum;
   logic [cfe_pkg::BYTE_W-1:0] base_left;
   logic                       take_data;
   logic                       close_frame;
   logic                       zero_len;

   assign zero_len   = (length == '0);
   assign header_sum = device + command + length;

   // A start carries a payload byte unless its length is zero.
   assign take_data = frame_start ? !zero_len : in_frame_ff;
   assign base_sum  = frame_start ? header_sum : sum_ff;
   assign base_left = frame_start ? length : left_ff;

   always_comb begin
      sum_in      = sum_ff;
      left_in     = left_ff;
      in_frame_in = in_frame_ff;
      close_frame = 1'b0;
      if (frame_start && zero_len) begin
         sum_in      = header_sum;
         left_in     = '0;
         in_frame_in = 1'b0;
         close_frame = 1'b1;
      end else if (take_data) begin
         sum_in      = base_sum + data_byte;
         left_in     = base_left - cfe_pkg::BYTE_W'(1);
         close_frame = (left_in == '0);
         in_frame_in = !close_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         left_ff     <= '0;
         in_frame_ff <= 1'b0;
      end else if (accept) begin
         sum_ff      <= sum_in;
         left_ff     <= left_in;
         in_frame_ff <= in_frame_in;
      end
   end

   // A non-start item while idle produces no job.
   assign job_push = accept && (frame_start || in_frame_ff);

   always_comb begin
      job.has_header   = frame_start;
      job.has_data     = take_data;
      job.has_checksum = close_frame;
      job.device       = device;
      job.command      = command;
      job.length       = length;
      job.data_byte    = data_byte;
      job.checksum     = ~sum_in;
   end

endmodule

FILE: rtl/cfe_queue.sv
// ----------------------------------------------------------------------------
// Command frame encoder job queue
// Small first-in first-out store of jobs between the front and the back.
// ----------------------------------------------------------------------------
module cfe_queue #(
   parameter int DEPTH = cfe_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cfe_pkg::job_type push_job,
   input  logic             pop,
   output cfe_pkg::job_type head_job,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cfe_pkg::job_type   entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/cfe_back.sv
// ----------------------------------------------------------------------------
// Command frame encoder back end
// Walks the bytes of the head job and feeds them into the output register.
// ----------------------------------------------------------------------------
module cfe_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_empty,
   input  cfe_pkg::job_type           job,
   output logic                       job_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [cfe_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                       rsp_last_of_run,
   output logic                       rsp_frame_end
);

   cfe_pkg::step_type          step_ff, step_in;
   cfe_pkg::step_type          cur_step;
   cfe_pkg::step_type          nxt_step;
   logic                       mid_ff, mid_in;
   logic                       run_done;
   logic                       emit;
   logic [cfe_pkg::BYTE_W-1:0] cur_byte;
   logic                       cur_end;

   logic                       valid_ff;
   logic [cfe_pkg::BYTE_W-1:0] byte_ff;
   logic                       last_ff;
   logic                       end_ff;

   // The first byte of a job depends on which parts the job carries.
   always_comb begin
      if (mid_ff) begin
         cur_step = step_ff;
      end else if (job.has_header) begin
         cur_step = cfe_pkg::STEP_SYNC_A;
      end else if (job.has_data) begin
         cur_step = cfe_pkg::STEP_DATA;
      end else begin
         cur_step = cfe_pkg::STEP_CHECKSUM;
      end
   end

   // Next step within the job, and whether the current byte ends the job.
   always_comb begin
      nxt_step = cur_step;
      run_done = 1'b0;
      unique case (cur_step)
         cfe_pkg::STEP_SYNC_A:  nxt_step = cfe_pkg::STEP_SYNC_B;
         cfe_pkg::STEP_SYNC_B:  nxt_step = cfe_pkg::STEP_DEVICE;
         cfe_pkg::STEP_DEVICE:  nxt_step = cfe_pkg::STEP_COMMAND;
         cfe_pkg::STEP_COMMAND: nxt_step = cfe_pkg::STEP_LENGTH;
         cfe_pkg::STEP_LENGTH: begin
            if (job.has_data) begin
               nxt_step = cfe_pkg::STEP_DATA;
            end else if (job.has_checksum) begin
               nxt_step = cfe_pkg::STEP_CHECKSUM;
            end else begin
               run_done = 1'b1;
            end
         end
         cfe_pkg::STEP_DATA: begin
            if (job.has_checksum) begin
               nxt_step = cfe_pkg::STEP_CHECKSUM;
            end else begin
               run_done = 1'b1;
            end
         end
         cfe_pkg::STEP_CHECKSUM: run_done = 1'b1;
         default:                run_done = 1'b1;
      endcase
   end

   // Byte selection for the current step.
   always_comb begin
      cur_byte = job.checksum;
      cur_end  = 1'b0;
      unique case (cur_step)
         cfe_pkg::STEP_SYNC_A:   cur_byte = cfe_pkg::SYNC_FIRST;
         cfe_pkg::STEP_SYNC_B:   cur_byte = cfe_pkg::SYNC_SECOND;
         cfe_pkg::STEP_DEVICE:   cur_byte = job.device;
         cfe_pkg::STEP_COMMAND:  cur_byte = job.command;
         cfe_pkg::STEP_LENGTH:   cur_byte = job.length;
         cfe_pkg::STEP_DATA:     cur_byte = job.data_byte;
         cfe_pkg::STEP_CHECKSUM: cur_end  = 1'b1;
         default:                cur_end  = 1'b1;
      endcase
   end

   assign emit    = !job_empty && (!valid_ff || rsp_pop);
   assign job_pop = emit && run_done;

   always_comb begin
      step_in = step_ff;
      mid_in  = mid_ff;
      if (emit) begin
         step_in = nxt_step;
         mid_in  = !run_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= cfe_pkg::STEP_SYNC_A;
         mid_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         mid_ff  <= mid_in;
         if (emit) begin
            valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= cur_byte;
         last_ff <= run_done;
         end_ff  <= cur_end;
      end
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_frame_end   = end_ff;

endmodule

FILE: test/command_frame_encoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Command frame encoder testbench
// Drives frame starts and payload items through the queue-style request port
// and checks every byte of the serial frame against an in-bench predictor.
// ----------------------------------------------------------------------------
module command_frame_encoder_top_tb;

   typedef logic [cfe_pkg::BYTE_W-1:0] byte_type;

   // One input item, field for field as on the req_ ports.
   typedef struct packed {
      logic     frame_start;
      byte_type device;
      byte_type command;
      byte_type length;
      byte_type data_byte;
   } frame_item_type;

   // One output byte, field for field as on the rsp_ ports.
   typedef struct packed {
      byte_type out_byte;
      logic     last_of_run;
      logic     frame_end;
   } frame_byte_type;

   // A directed row. Where typed is set, the row also carries the number of
   // bytes the item must produce and the value of its final byte, both read
   // straight off the frame format rather than taken from the predictor.
   typedef struct packed {
      frame_item_type item;
      logic           typed;
      logic [2:0]     typed_count;
      byte_type       typed_tail;
   } directed_row_type;

   localparam int RANDOM_ITEMS   = 90;
   localparam int QUIET_ITEMS    = 30;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int NUM_ROWS       = 19;

   logic     clock = 1'b0;
   logic     reset;
   logic     req_push;
   logic     req_full;
   logic     req_frame_start;
   byte_type req_device;
   byte_type req_command;
   byte_type req_length;
   byte_type req_data_byte;
   logic     rsp_empty;
   logic     rsp_pop;
   byte_type rsp_out_byte;
   logic     rsp_last_of_run;
   logic     rsp_frame_end;

   command_frame_encoder_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_frame_start (req_frame_start),
      .req_device      (req_device),
      .req_command     (req_command),
      .req_length      (req_length),
      .req_data_byte   (req_data_byte),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_end   (rsp_frame_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The directed table. The first rows hit the plain cases: a payload item
   // while idle, zero-length frames with all-zero and all-one headers (whose
   // data byte must be ignored), and a one-byte frame whose checksum follows
   // at once. Later rows cover a start that abandons an open frame, the
   // largest length, checksum wrap and a short complete frame.
   directed_row_type directed_rows [NUM_ROWS] = '{
      '{'{1'b0, 8'h00, 8'h00, 8'h00, 8'hFF}, 1'b1, 3'd0, 8'h00},
      '{'{1'b1, 8'h00, 8'h00, 8'h00, 8'hFF}, 1'b1, 3'd6, 8'hFF},
      '{'{1'b1, 8'hFF, 8'hFF, 8'h00, 8'h00}, 1'b1, 3'd6, 8'h01},
      '{'{1'b1, 8'hFF, 8'hFF, 8'h01, 8'hFF}, 1'b1, 3'd7, 8'h01},
      '{'{1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hAA}, 1'b1, 3'd0, 8'h00},
      '{'{1'b1, 8'h12, 8'h34, 8'h03, 8'h56}, 1'b0, 3'd0, 8'h00},
      '{'{1'b0, 8'h00, 8'h00, 8'h00, 8'hAA}, 1'b0, 3'd0, 8'h00},
      '{'{1'b1, 8'h01, 8'h02, 8'h02, 8'h03}, 1'b0, 3'd0, 8'h00},
      '{'{1'b0, 8'h00, 8'h00, 8'h00, 8'hFF}, 1'b0, 3'd0, 8'h00},
      '{'{1'b1, 8'h00, 8'h00, 8'hFF, 8'h00}, 1'b1, 3'd6, 8'h00},
      '{'{1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 3'd0, 8'h00},
      '{'{1'b1, 8'h80, 8'h80, 8'h02, 8'h80}, 1'b0, 3'd0, 8'h00},
      '{'{1'b0, 8'h00, 8'h00, 8'h00, 8'h7F}, 1'b0, 3'd0, 8'h00},
      '{'{1'b0, 8'h00, 8'h00, 8'h00, 8'h55}, 1'b1, 3'd0, 8'h00},
      '{'{1'b1, 8'h5A, 8'hA5, 8'h04, 8'h00}, 1'b0, 3'd0, 8'h00},
      '{'{1'b0, 8'h00, 8'h00, 8'h00, 8'hFF}, 1'b0, 3'd0, 8'h00},
      '{'{1'b0, 8'h00, 8'h00, 8'h00, 8'h01}, 1'b0, 3'd0, 8'h00},
      '{'{1'b0, 8'h00, 8'h00, 8'h00, 8'hFE}, 1'b0, 3'd0, 8'h00},
      '{'{1'b1, 8'hAA, 8'h55, 8'h01, 8'h33}, 1'b0, 3'd0, 8'h00}
   };

   // Predictor state: a private copy of the frame tracking that the block
   // keeps, advanced once for every item the block accepts.
   byte_type frame_sum;
   byte_type payload_left;
   logic     frame_open;

   // Bytes the block still owes, oldest first.
   frame_byte_type pending_bytes [$];

   int mismatches;
   int items_with_results;
   int idle_cycles;

   // Shared between the sender and the receiver processes.
   bit quiet;
   bit long_hold_req;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic void queue_byte(input byte_type value, input logic is_checksum);
      frame_byte_type b;
      b.out_byte    = value;
      b.last_of_run = 1'b0;
      b.frame_end   = is_checksum;
      pending_bytes.push_back(b);
   endfunction

   // A payload byte goes out as is and joins the running sum; when it is the
   // last one, the inverted sum closes the frame.
   function automatic void queue_payload(input byte_type value);
      queue_byte(value, 1'b0);
      frame_sum    = frame_sum + value;
      payload_left = payload_left - 8'd1;
      if (payload_left == 8'd0) begin
         queue_byte(~frame_sum, 1'b1);
         frame_open = 1'b0;
      end
   endfunction

   // Works out the bytes caused by one accepted item, queues them, and
   // returns how many there are.
   function automatic int predict_frame_bytes(input frame_item_type it);
      int depth_before;
      frame_byte_type tail;
      depth_before = pending_bytes.size();
      if (it.frame_start) begin
         queue_byte(cfe_pkg::SYNC_FIRST, 1'b0);
         queue_byte(cfe_pkg::SYNC_SECOND, 1'b0);
         queue_byte(it.device, 1'b0);
         queue_byte(it.command, 1'b0);
         queue_byte(it.length, 1'b0);
         frame_sum    = it.device + it.command + it.length;
         payload_left = it.length;
         if (it.length == 8'd0) begin
            queue_byte(~frame_sum, 1'b1);
            frame_open = 1'b0;
         end else begin
            frame_open = 1'b1;
            queue_payload(it.data_byte);
         end
      end else if (frame_open) begin
         queue_payload(it.data_byte);
      end
      if (pending_bytes.size() > depth_before) begin
         tail = pending_bytes.pop_back();
         tail.last_of_run = 1'b1;
         pending_bytes.push_back(tail);
      end
      return pending_bytes.size() - depth_before;
   endfunction

   function automatic frame_item_type random_item(input logic is_start);
      frame_item_type it;
      it.frame_start = is_start;
      it.device      = byte_type'($urandom_range(0, 255));
      it.command     = byte_type'($urandom_range(0, 255));
      it.length      = byte_type'($urandom_range(0, 255));
      it.data_byte   = byte_type'($urandom_range(0, 255));
      return it;
   endfunction

   // Offers one item and waits for the edge that takes it. The predictor runs
   // at that edge, well before the first byte can come out.
   task automatic send_item(input frame_item_type it, output int produced);
      req_push        <= 1'b1;
      req_frame_start <= it.frame_start;
      req_device      <= it.device;
      req_command     <= it.command;
      req_length      <= it.length;
      req_data_byte   <= it.data_byte;
      do @(posedge clock); while (req_full);
      produced = predict_frame_bytes(it);
      if (produced > 0) items_with_results++;
   endtask

   // A random burst of idle cycles between items, except in the last part.
   task automatic sender_gap();
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // Stops offering until every byte owed has come out. It waits on the clock
   // before it checks, so a lowered push never shares a time step with a raise.
   task automatic drain_results();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_bytes.size() != 0);
   endtask

   // A start followed by a number of payload items. With payloads equal to
   // length minus one the frame completes; with fewer it is left open, and
   // whatever start comes next abandons it.
   task automatic send_frame(input int len, input int payloads);
      frame_item_type it;
      int produced;
      int i;
      it = random_item(1'b1);
      it.length = byte_type'(len);
      send_item(it, produced);
      sender_gap();
      for (i = 0; i < payloads; i++) begin
         send_item(random_item(1'b0), produced);
         sender_gap();
      end
   endtask

   // Sender: reset, the directed table, then random frames.
   initial begin : stimulus
      int row;
      int produced;
      int pick;
      int len;
      bit mid_pause_done;
      frame_byte_type tail;
      reset           = 1'b1;
      req_push        = 1'b0;
      req_frame_start = 1'b0;
      req_device      = '0;
      req_command     = '0;
      req_length      = '0;
      req_data_byte   = '0;
      quiet           = 1'b0;
      long_hold_req   = 1'b0;
      mismatches      = 0;
      frame_sum       = '0;
      payload_left    = '0;
      frame_open      = 1'b0;
      mid_pause_done  = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed rows. On a typed row the hand-written final byte replaces
      // the predicted one, so the block is held to the value in the table.
      for (row = 0; row < NUM_ROWS; row++) begin
         send_item(directed_rows[row].item, produced);
         if (directed_rows[row].typed) begin
            if (produced != directed_rows[row].typed_count) begin
               report_mismatch("byte count of a directed row", produced,
                               directed_rows[row].typed_count);
            end else if (produced > 0) begin
               tail = pending_bytes.pop_back();
               tail.out_byte = directed_rows[row].typed_tail;
               pending_bytes.push_back(tail);
            end
         end
         sender_gap();
      end

      // Let everything drain before the random part; this is also the first
      // pause that waits for every owed byte.
      drain_results();

      // The receiver now holds off for a long stretch while items keep
      // coming, so the job queue fills and req_full has to rise.
      items_with_results = 0;
      long_hold_req = 1'b1;

      // Mostly complete frames of small length with random content. One in
      // ten picks is a loose payload item, and one in ten is a frame that is
      // left unfinished and then abandoned by the next start.
      while (items_with_results < RANDOM_ITEMS) begin
         if (items_with_results >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            send_item(random_item(1'b0), produced);
            sender_gap();
         end else if (pick == 1) begin
            len = $urandom_range(2, 255);
            send_frame(len, $urandom_range(0, (len - 2 < 6) ? len - 2 : 6));
         end else begin
            pick = $urandom_range(0, 15);
            if (pick == 0)       len = 0;
            else if (pick == 1)  len = 1;
            else if (pick == 15) len = $urandom_range(9, 40);
            else                 len = $urandom_range(2, 8);
            send_frame(len, (len == 0) ? 0 : len - 1);
         end
         if (!mid_pause_done && items_with_results >= RANDOM_ITEMS / 2) begin
            drain_results();
            mid_pause_done = 1'b1;
         end
      end

      // Wait for the last owed byte, then watch a while for strays.
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_bytes.size() != 0) begin
         report_mismatch("bytes never delivered", 0, pending_bytes.size());
      end
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Receiver: pops whenever it can, with random stall bursts, one long
   // hold-off on request, and no stalls at all once the run turns quiet.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_pop   = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_pop <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD - 1;
            rsp_pop <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(1, 17) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Every byte taken off the result port is compared with the oldest byte
   // owed, field by field.
   always @(posedge clock) begin
      frame_byte_type owed;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_bytes.size() == 0) begin
            report_mismatch("byte with nothing owed", rsp_out_byte, 0);
         end else begin
            owed = pending_bytes.pop_front();
            if (rsp_out_byte !== owed.out_byte)
               report_mismatch("out_byte", rsp_out_byte, owed.out_byte);
            if (rsp_last_of_run !== owed.last_of_run)
               report_mismatch("last_of_run", rsp_last_of_run, owed.last_of_run);
            if (rsp_frame_end !== owed.frame_end)
               report_mismatch("frame_end", rsp_frame_end, owed.frame_end);
         end
      end
   end

   // Watchdog: the run is stuck if neither port moves for too long. The
   // longest legal quiet spell is the receiver's long hold-off.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule

FILE: filelist.f
rtl/cfe_pkg.sv
rtl/cfe_front.sv
rtl/cfe_queue.sv
rtl/cfe_back.sv
rtl/command_frame_encoder_top.sv
test/command_frame_encoder_top_tb.sv
